/* rtl/cigrm_pkg.sv */
// Shared types, constants and a helper function for the CIGAR run merge stack.
package cigrm_pkg;

   // Stack geometry and field widths.
   localparam int STACK_DEPTH = 32;
   localparam int LEN_W       = 28;
   localparam int CODE_W      = 4;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int MEM_DEPTH   = STACK_DEPTH - 1;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   // Operation codes that the reduction rules name.
   localparam logic [CODE_W-1:0] CODE_M = 4'd0;
   localparam logic [CODE_W-1:0] CODE_S = 4'd4;

   // Operation classes: bit 0 consumes query, bit 1 consumes reference.
   localparam logic [1:0] OPC_QUERY = 2'd1;
   localparam logic [1:0] OPC_REF   = 2'd2;

   // Class of every code, two bits per code, code 0 in the low bits.
   localparam logic [31:0] CLASS_TABLE = 32'h0003_C1A7;

   // Request kinds.
   localparam logic REQ_PUSH  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [LEN_W-1:0]  op_len;
      logic [CODE_W-1:0] op_code;
   } req_item_type;

   typedef struct packed {
      logic [LEN_W-1:0]  out_len;
      logic [CODE_W-1:0] out_code;
      logic              entry_valid;
      logic              overflow;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push;
      logic cancel_start;
      logic cancel_finish;
      logic flush_start;
      logic load_mem;
      logic load_top;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cancel_needs_below;
      logic has_below;
      logic idx_last;
      logic out_free;
   } status_type;

   // Looks up the query/reference class of an operation code.
   function automatic logic [1:0] op_class(input logic [CODE_W-1:0] code);
      op_class = CLASS_TABLE[{code, 1'b0} +: 2];
   endfunction

endpackage

/* rtl/cigrm_ctrl.sv */
// Controller state machine that sequences pushes, cancels and flushes.
module cigrm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_kind,
   input  cigrm_pkg::status_type  status,
   output cigrm_pkg::cmd_type     cmd,
   output logic                   req_ready
);

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_CANCEL    = 2'd1;
   localparam logic [1:0] ST_FLUSH_MEM = 2'd2;
   localparam logic [1:0] ST_FLUSH_TOP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // New requests are taken only between operations.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == cigrm_pkg::REQ_PUSH) begin
                  if (status.cancel_needs_below) begin
                     cmd.cancel_start = 1'b1;
                     state_in         = ST_CANCEL;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end else if (status.has_below) begin
                  cmd.flush_start = 1'b1;
                  state_in        = ST_FLUSH_MEM;
               end else begin
                  state_in = ST_FLUSH_TOP;
               end
            end
         end
         ST_CANCEL: begin
            cmd.cancel_finish = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_FLUSH_MEM: begin
            if (status.out_free) begin
               cmd.load_mem = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_FLUSH_TOP;
               end
            end
         end
         ST_FLUSH_TOP: begin
            if (status.out_free) begin
               cmd.load_top = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/cigrm_dp.sv */
// Datapath: top-of-stack register, stack memory, counters and output register.
module cigrm_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  cigrm_pkg::req_item_type  req_data,
   input  logic                     csr_valid,
   input  logic                     csr_data,
   input  cigrm_pkg::cmd_type       cmd,
   output cigrm_pkg::status_type    status,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output cigrm_pkg::rsp_item_type  rsp_data
);

   // The top entry lives in registers; entries below it live in the memory.
   cigrm_pkg::entry_type stack_mem_ff [cigrm_pkg::MEM_DEPTH];
   cigrm_pkg::entry_type rd_data_ff;
   cigrm_pkg::entry_type top_ff;
   cigrm_pkg::entry_type top_in;
   logic [cigrm_pkg::CNT_W-1:0]  count_ff;
   logic [cigrm_pkg::CNT_W-1:0]  count_in;
   logic                         ovf_ff;
   logic                         ovf_in;
   logic                         reduce_disable_ff;
   logic [cigrm_pkg::ADDR_W-1:0] flush_idx_ff;
   logic [cigrm_pkg::ADDR_W-1:0] flush_idx_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   cigrm_pkg::rsp_item_type      rsp_data_ff;
   cigrm_pkg::rsp_item_type      rsp_data_in;

   logic                         wr_en;
   logic [cigrm_pkg::ADDR_W-1:0] wr_addr;
   cigrm_pkg::entry_type         wr_data;
   logic                         rd_en;
   logic [cigrm_pkg::ADDR_W-1:0] rd_addr;

   logic [cigrm_pkg::LEN_W-1:0]  new_len;
   logic [cigrm_pkg::CODE_W-1:0] new_code;
   logic [cigrm_pkg::CNT_W-1:0]  count_m1;
   logic [cigrm_pkg::CNT_W-1:0]  count_m2;
   logic [cigrm_pkg::ADDR_W-1:0] top_addr;
   logic [cigrm_pkg::ADDR_W-1:0] below_addr;
   logic                         count_zero;
   logic                         count_full;
   logic [1:0]                   top_class;
   logic [1:0]                   new_class;
   logic                         is_merge;
   logic                         is_cancel;
   logic                         len_eq;
   logic                         len_gt;
   logic [cigrm_pkg::LEN_W-1:0]  diff_up;
   logic [cigrm_pkg::LEN_W-1:0]  diff_dn;
   logic [cigrm_pkg::LEN_W-1:0]  add_b;
   logic [cigrm_pkg::LEN_W:0]    add_sum;
   logic                         add_over;
   logic [cigrm_pkg::LEN_W-1:0]  add_sat;
   logic                         do_append;
   logic                         out_free;

   assign new_len  = req_data.op_len;
   assign new_code = req_data.op_code;

   // Stack addresses and fill state.
   assign count_m1   = count_ff - cigrm_pkg::CNT_W'(1);
   assign count_m2   = count_ff - cigrm_pkg::CNT_W'(2);
   assign top_addr   = count_m1[cigrm_pkg::ADDR_W-1:0];
   assign below_addr = count_m2[cigrm_pkg::ADDR_W-1:0];
   assign count_zero = (count_ff == '0);
   assign count_full = (count_ff == cigrm_pkg::CNT_W'(cigrm_pkg::STACK_DEPTH));

   // Classification of the pushed element against the top entry.
   assign top_class = cigrm_pkg::op_class(top_ff.code);
   assign new_class = cigrm_pkg::op_class(new_code);
   assign is_merge  = (top_ff.code == new_code) ||
                      ((top_class == cigrm_pkg::OPC_QUERY) &&
                       (new_class == cigrm_pkg::OPC_QUERY));
   assign is_cancel = ((top_class == cigrm_pkg::OPC_REF) &&
                       (new_class == cigrm_pkg::OPC_QUERY)) ||
                      ((top_class == cigrm_pkg::OPC_QUERY) &&
                       (new_class == cigrm_pkg::OPC_REF));
   assign len_eq    = (new_len == top_ff.len);
   assign len_gt    = (new_len > top_ff.len);
   assign diff_up   = new_len - top_ff.len;
   assign diff_dn   = top_ff.len - new_len;

   // One saturating adder, shared by merges and by the cancel follow-up.
   assign add_b    = cmd.cancel_finish ? rd_data_ff.len : new_len;
   assign add_sum  = {1'b0, top_ff.len} + {1'b0, add_b};
   assign add_over = add_sum[cigrm_pkg::LEN_W];
   assign add_sat  = add_over ? cigrm_pkg::LEN_MAX : add_sum[cigrm_pkg::LEN_W-1:0];

   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Status toward the controller.
   always_comb begin
      status.cancel_needs_below = (new_len != '0) && !reduce_disable_ff &&
                                  (count_ff > cigrm_pkg::CNT_W'(1)) && is_cancel &&
                                  (top_ff.code != cigrm_pkg::CODE_S) && len_eq;
      status.has_below = (count_ff > cigrm_pkg::CNT_W'(1));
      status.idx_last  = (flush_idx_ff == below_addr);
      status.out_free  = out_free;
   end

   // Next-state logic for the stack, the flag and the output register.
   always_comb begin
      top_in       = top_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      flush_idx_in = flush_idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = top_addr;
      wr_data      = top_ff;
      rd_en        = 1'b0;
      rd_addr      = below_addr;
      do_append    = 1'b0;

      if (cmd.push && (new_len != '0)) begin
         if (count_zero || reduce_disable_ff) begin
            do_append = 1'b1;
         end else if (is_merge) begin
            top_in.len = add_sat;
            if (add_over) begin
               ovf_in = 1'b1;
            end
         end else if (is_cancel) begin
            if (top_ff.code == cigrm_pkg::CODE_S) begin
               // A reference-only element after a soft clip is dropped.
               top_in = top_ff;
            end else if (len_eq) begin
               // Exact cancel of the only entry leaves a single M.
               top_in.code = cigrm_pkg::CODE_M;
            end else if (len_gt) begin
               // Top turns into M, the rest of the new element goes on top.
               if (count_full) begin
                  top_in.code = cigrm_pkg::CODE_M;
                  ovf_in      = 1'b1;
               end else begin
                  wr_en        = 1'b1;
                  wr_data.len  = top_ff.len;
                  wr_data.code = cigrm_pkg::CODE_M;
                  top_in.len   = diff_up;
                  top_in.code  = new_code;
                  count_in     = count_ff + cigrm_pkg::CNT_W'(1);
               end
            end else begin
               // Top keeps its remainder, an M of the new length goes on top.
               if (count_full) begin
                  top_in.len = diff_dn;
                  ovf_in     = 1'b1;
               end else begin
                  wr_en        = 1'b1;
                  wr_data.len  = diff_dn;
                  wr_data.code = top_ff.code;
                  top_in.len   = new_len;
                  top_in.code  = cigrm_pkg::CODE_M;
                  count_in     = count_ff + cigrm_pkg::CNT_W'(1);
               end
            end
         end else begin
            do_append = 1'b1;
         end
      end

      // Plain append: the old top moves into the memory.
      if (do_append) begin
         if (count_full) begin
            ovf_in = 1'b1;
         end else begin
            wr_en       = !count_zero;
            top_in.len  = new_len;
            top_in.code = new_code;
            count_in    = count_ff + cigrm_pkg::CNT_W'(1);
         end
      end

      // Exact cancel with an entry below: fetch it.
      if (cmd.cancel_start) begin
         rd_en   = 1'b1;
         rd_addr = below_addr;
      end

      // Exact cancel follow-up: merge into an M below, else replace the top by M.
      if (cmd.cancel_finish) begin
         if (rd_data_ff.code == cigrm_pkg::CODE_M) begin
            top_in.len  = add_sat;
            top_in.code = cigrm_pkg::CODE_M;
            count_in    = count_m1;
            if (add_over) begin
               ovf_in = 1'b1;
            end
         end else begin
            top_in.code = cigrm_pkg::CODE_M;
         end
      end

      // Flush: read the bottom entry first.
      if (cmd.flush_start) begin
         rd_en        = 1'b1;
         rd_addr      = '0;
         flush_idx_in = '0;
      end

      // Flush: hand out one memory entry and fetch the next.
      if (cmd.load_mem) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_len      = rd_data_ff.len;
         rsp_data_in.out_code     = rd_data_ff.code;
         rsp_data_in.entry_valid  = 1'b1;
         rsp_data_in.overflow     = ovf_ff;
         rsp_data_in.last         = 1'b0;
         flush_idx_in             = flush_idx_ff + cigrm_pkg::ADDR_W'(1);
         if (!status.idx_last) begin
            rd_en   = 1'b1;
            rd_addr = flush_idx_ff + cigrm_pkg::ADDR_W'(1);
         end
      end

      // Flush: hand out the top entry, or an empty marker, and clear.
      if (cmd.load_top) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_len     = count_zero ? '0 : top_ff.len;
         rsp_data_in.out_code    = count_zero ? '0 : top_ff.code;
         rsp_data_in.entry_valid = !count_zero;
         rsp_data_in.overflow    = ovf_ff;
         rsp_data_in.last        = 1'b1;
         count_in                = '0;
         ovf_in                  = 1'b0;
      end
   end

   // Stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem_ff[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff          <= '0;
         ovf_ff            <= 1'b0;
         reduce_disable_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            reduce_disable_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      flush_idx_ff <= flush_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/cigar_run_merge_stack_unit.sv */
// Top level of the CIGAR run merge stack: controller, datapath and checks.
//
//  Channel  Direction  Handshake              Carries
//  req_     in         req_valid / req_ready  push or flush request (req_item_type)
//  rsp_     out        rsp_valid / rsp_ready  one emitted stack entry (rsp_item_type)
//  csr_     in         csr_valid / csr_ready  reduce_disable bit, always ready
//
// A push completes while idle; an exact cancel with an entry below also passes
// through the cancel state, as the entry below the top comes from the stack
// memory's registered read port. A flush holds the input until it is done:
// the bottom entry is read ahead, then one entry leaves per cycle, top last.
// A stalled output holds the flush in place for as long as rsp_ready is low.
// Reset clears the stack count, the overflow flag, reduce_disable and the output valid.
module cigar_run_merge_stack_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cigrm_pkg::req_item_type  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cigrm_pkg::rsp_item_type  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   cigrm_pkg::cmd_type    cmd;
   cigrm_pkg::status_type status;

   assign csr_ready = 1'b1;

   cigrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   cigrm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A flush request blocks further requests while it streams out.
   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.req_type == cigrm_pkg::REQ_FLUSH))
      |=> !req_ready)
      else $error("request accepted right after a flush request");

   // A push never produces a response.
   a_push_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.req_type == cigrm_pkg::REQ_PUSH) && !rsp_valid)
      |=> !rsp_valid)
      else $error("response appeared after a push request");

   // An empty-flush marker is always the final response and carries no entry.
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.entry_valid)
      |-> (rsp_data.last && (rsp_data.out_len == '0) && (rsp_data.out_code == '0)))
      else $error("empty-flush marker malformed");
`endif

endmodule

/* bench/cigar_run_merge_stack_unit_tb.sv */
// Self-checking testbench for the CIGAR run merge stack: directed, overflow, stall and random runs.
module cigar_run_merge_stack_unit_tb;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_LIMIT   = 50000;
   localparam int RUN_LIMIT     = 20 * 400000;
   localparam int PRINT_LIMIT   = 50;
   localparam int RANDOM_BUDGET = 32;

   // Local copies of the package constants used throughout.
   localparam int                LEN_W       = cigrm_pkg::LEN_W;
   localparam int                CODE_W      = cigrm_pkg::CODE_W;
   localparam int                STACK_DEPTH = cigrm_pkg::STACK_DEPTH;
   localparam logic [LEN_W-1:0]  LEN_MAX     = cigrm_pkg::LEN_MAX;
   localparam logic [CODE_W-1:0] CODE_M      = cigrm_pkg::CODE_M;
   localparam logic [CODE_W-1:0] CODE_S      = cigrm_pkg::CODE_S;
   localparam logic [1:0]        OPC_QUERY   = cigrm_pkg::OPC_QUERY;
   localparam logic [1:0]        OPC_REF     = cigrm_pkg::OPC_REF;

   // Operation codes beyond the two that the package names.
   localparam logic [CODE_W-1:0] OP_INS  = 4'd1;
   localparam logic [CODE_W-1:0] OP_DEL  = 4'd2;
   localparam logic [CODE_W-1:0] OP_SKIP = 4'd3;
   localparam logic [CODE_W-1:0] OP_HARD = 4'd5;
   localparam logic [CODE_W-1:0] OP_PAD  = 4'd6;
   localparam logic [CODE_W-1:0] OP_EQ   = 4'd7;
   localparam logic [CODE_W-1:0] OP_DIFF = 4'd8;
   localparam logic [CODE_W-1:0] OP_NONE = 4'd15;

   // Consumption classes not named in the package.
   localparam logic [1:0] OPC_NONE = 2'd0;
   localparam logic [1:0] OPC_BOTH = OPC_QUERY | OPC_REF;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   cigrm_pkg::req_item_type req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   cigrm_pkg::rsp_item_type rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic                    csr_data = 1'b0;

   // Predicted stack contents, flag and mode.
   cigrm_pkg::entry_type    cigar_stack [STACK_DEPTH];
   int                      cigar_depth = 0;
   logic                    cigar_overflow = 1'b0;
   logic                    reduce_off = 1'b0;
   cigrm_pkg::rsp_item_type expected_entries [$];

   int mismatch_count = 0;
   int burst_left = 1;

   // Receiver stall control; the test only bumps hold_asks.
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stretch_left = 0;
   int ready_mode = 0;

   cigar_run_merge_stack_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Prints one mismatch line (up to a cap) and counts every one.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Which of query and reference an operation consumes.
   function automatic logic [1:0] consume_class(input logic [CODE_W-1:0] code);
      case (code)
         CODE_M, OP_EQ, OP_DIFF: return OPC_BOTH;
         OP_INS, CODE_S:         return OPC_QUERY;
         OP_DEL, OP_SKIP:        return OPC_REF;
         default:                return OPC_NONE;
      endcase
   endfunction

   // Adds two run lengths, pinning the sum at the largest length.
   function automatic logic [LEN_W-1:0] add_len(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
      logic [LEN_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum > {1'b0, LEN_MAX}) begin
         cigar_overflow = 1'b1;
         return LEN_MAX;
      end
      return sum[LEN_W-1:0];
   endfunction

   // Appends an entry unless the stack is already full.
   function automatic void stack_append(input logic [LEN_W-1:0] len,
                                        input logic [CODE_W-1:0] code);
      if (cigar_depth >= STACK_DEPTH) begin
         cigar_overflow = 1'b1;
      end else begin
         cigar_stack[cigar_depth].len  = len;
         cigar_stack[cigar_depth].code = code;
         cigar_depth++;
      end
   endfunction

   // Applies one pushed element with the merge and cancel rules.
   function automatic void cigar_push(input logic [LEN_W-1:0] len,
                                      input logic [CODE_W-1:0] code);
      int         t;
      logic [1:0] top_class;
      logic [1:0] new_class;
      if (len == 0) return;
      if (cigar_depth == 0 || reduce_off) begin
         stack_append(len, code);
         return;
      end
      t = cigar_depth - 1;
      top_class = consume_class(cigar_stack[t].code);
      new_class = consume_class(code);
      if (cigar_stack[t].code == code || (top_class == OPC_QUERY && new_class == OPC_QUERY)) begin
         cigar_stack[t].len = add_len(cigar_stack[t].len, len);
      end else if ((top_class == OPC_REF && new_class == OPC_QUERY) ||
                   (top_class == OPC_QUERY && new_class == OPC_REF)) begin
         // A reference-only element right after a soft clip disappears.
         if (cigar_stack[t].code == CODE_S) return;
         if (len == cigar_stack[t].len) begin
            // Exact cancel: drop the top, then fold an M of that length back in.
            cigar_depth--;
            if (cigar_depth != 0 && cigar_stack[cigar_depth - 1].code == CODE_M) begin
               cigar_stack[cigar_depth - 1].len = add_len(cigar_stack[cigar_depth - 1].len, len);
            end else begin
               stack_append(len, CODE_M);
            end
         end else if (len > cigar_stack[t].len) begin
            cigar_stack[t].code = CODE_M;
            stack_append(len - cigar_stack[t].len, code);
         end else begin
            cigar_stack[t].len = cigar_stack[t].len - len;
            stack_append(len, CODE_M);
         end
      end else begin
         stack_append(len, code);
      end
   endfunction

   // Queues every stored entry, or one empty marker, then clears the stack.
   function automatic void cigar_flush();
      cigrm_pkg::rsp_item_type item;
      if (cigar_depth == 0) begin
         item = '0;
         item.overflow = cigar_overflow;
         item.last = 1'b1;
         expected_entries = {expected_entries, item};
      end
      for (int i = 0; i < cigar_depth; i++) begin
         item.out_len     = cigar_stack[i].len;
         item.out_code    = cigar_stack[i].code;
         item.entry_valid = 1'b1;
         item.overflow    = cigar_overflow;
         item.last        = (i == cigar_depth - 1);
         expected_entries = {expected_entries, item};
      end
      cigar_depth = 0;
      cigar_overflow = 1'b0;
   endfunction

   // Compares each accepted result with the oldest expected entry.
   always @(posedge clock) begin
      cigrm_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_entries.size() == 0) begin
            report_mismatch("result with nothing expected", 32'(rsp_data.out_len), 0);
         end else begin
            want = expected_entries.pop_front();
            if (rsp_data.out_len !== want.out_len)
               report_mismatch("out_len", 32'(rsp_data.out_len), 32'(want.out_len));
            if (rsp_data.out_code !== want.out_code)
               report_mismatch("out_code", 32'(rsp_data.out_code), 32'(want.out_code));
            if (rsp_data.entry_valid !== want.entry_valid)
               report_mismatch("entry_valid", 32'(rsp_data.entry_valid),
                               32'(want.entry_valid));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", 32'(rsp_data.overflow), 32'(want.overflow));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
   end

   // Receiver: random stall stretches, plus a long hold-off when the test asks.
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            stretch_left = $urandom_range(8, 64);
         end
         stretch_left--;
         case (ready_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // Sends one request, predicts it once accepted, and idles between bursts.
   task automatic send_request(input cigrm_pkg::req_item_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.req_type == cigrm_pkg::REQ_FLUSH) cigar_flush();
      else cigar_push(item.op_len, item.op_code);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
   endtask

   task automatic send_push(input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code);
      cigrm_pkg::req_item_type item;
      item.req_type = cigrm_pkg::REQ_PUSH;
      item.op_len   = len;
      item.op_code  = code;
      send_request(item);
   endtask

   // A flush carries random length and code, which the block must ignore.
   task automatic send_flush();
      cigrm_pkg::req_item_type item;
      item.req_type = cigrm_pkg::REQ_FLUSH;
      item.op_len   = LEN_W'($urandom);
      item.op_code  = CODE_W'($urandom_range(0, 15));
      send_request(item);
   endtask

   // Stops sending until every expected result is back and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes reduce_disable while the block is idle.
   task automatic write_reduce_off(input logic value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reduce_off = value;
   endtask

   // Mostly the common codes, sometimes one that consumes nothing.
   function automatic logic [CODE_W-1:0] random_code();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 4) return CODE_M;
      if (pick < 7) return OP_INS;
      if (pick < 10) return OP_DEL;
      if (pick < 12) return CODE_S;
      case (pick)
         12:      return OP_SKIP;
         13:      return OP_EQ;
         14:      return OP_DIFF;
         15:      return OP_HARD;
         16:      return OP_PAD;
         default: return CODE_W'($urandom_range(9, 15));
      endcase
   endfunction

   // Short lengths so that exact cancels are common, with zero and huge ones mixed in.
   function automatic logic [LEN_W-1:0] random_len();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick == 1) return LEN_W'($urandom);
      if (pick == 2) return LEN_MAX - LEN_W'($urandom_range(0, 15));
      return LEN_W'($urandom_range(1, 8));
   endfunction

   // Directed cases: empty flush, zero length, merges, cancels, drops and saturation.
   task automatic test_directed();
      write_reduce_off(1'b0);
      send_flush();
      send_push(0, CODE_M);
      // Exact cancel on an otherwise empty stack leaves M6.
      send_push(6, OP_INS);
      send_push(6, OP_DEL);
      send_push(2, OP_SKIP);
      send_push(3, OP_EQ);
      send_push(1, OP_PAD);
      send_flush();
      // Exact cancel merging into the M below, then a partial cancel.
      send_push(4, CODE_M);
      send_push(3, OP_INS);
      send_push(3, OP_DEL);
      send_push(5, OP_DEL);
      send_push(2, CODE_S);
      send_push(9, OP_DIFF);
      send_push(9, OP_DIFF);
      send_flush();
      // Deletion after a soft clip, query merge, longer cancel and saturation.
      send_push(3, CODE_S);
      send_push(4, OP_DEL);
      send_push(1, OP_INS);
      send_push(7, OP_HARD);
      send_push(2, OP_NONE);
      send_push(7, OP_DEL);
      send_push(9, OP_INS);
      send_push(LEN_MAX, OP_INS);
      send_flush();
   endtask

   // Fills the stack past its depth with reduction off and then on.
   task automatic test_depth_overflow();
      write_reduce_off(1'b1);
      repeat (STACK_DEPTH + 2) begin
         send_push(LEN_W'($urandom_range(1, 100)), CODE_W'($urandom_range(0, 15)));
      end
      send_flush();
      write_reduce_off(1'b0);
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
         send_push(LEN_W'($urandom_range(1, 50)), (i % 2 != 0) ? OP_HARD : CODE_M);
      end
      send_push(5, OP_DEL);
      // The cancel rewrites the full top to M and loses the leftover insertion.
      send_push(8, OP_INS);
      send_push(1, CODE_M);
      send_flush();
   endtask

   // Holds the receiver off while requests keep coming, so the input stalls.
   task automatic test_output_backpressure();
      hold_asks <= hold_asks + 1;
      repeat (3) begin
         repeat (12) send_push(random_len(), random_code());
         send_flush();
      end
      wait_idle();
   endtask

   // Random sequences ending in a flush, plus some raw noise requests.
   task automatic run_random(input int budget);
      int sent;
      int n;
      cigrm_pkg::req_item_type noise;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 9) != 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 10);
            repeat (n) send_push(random_len(), random_code());
            send_flush();
            sent += n + 1;
            if ($urandom_range(0, 14) == 0) wait_idle();
         end else begin
            noise.req_type = ($urandom_range(0, 1) == 1);
            noise.op_len   = LEN_W'($urandom);
            noise.op_code  = CODE_W'($urandom);
            send_request(noise);
            sent++;
         end
      end
   endtask

   // Several random phases, switching the reduction mode between them.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         write_reduce_off(phase == 1 || phase == 4);
         run_random(RANDOM_BUDGET);
      end
   endtask

   // Waits for the last results with a limit and flags any that never came.
   task automatic finish_run();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_entries.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_entries.size() != 0)
         report_mismatch("results never seen", 0, 32'(expected_entries.size()));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_depth_overflow();
      test_output_backpressure();
      test_random_traffic();
      finish_run();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Ends a hung run.
   initial begin
      #(RUN_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
